FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("concurrent assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`endif
`endif

FILE: rtl/tdcsm_pkg.sv
// types, codes and constants of the character state machine
// no dependencies
`default_nettype none

package tdcsm_pkg;

  localparam int STATE_W = 4;
  localparam int CHAR_W  = 8;
  localparam int ACT_W   = 4;

  localparam int STATE_LIMIT     = 2 ** STATE_W;
  localparam int NUM_STATES_DEF  = 16;
  localparam int NUM_ACTIONS_DEF = 16;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_CHAR      = 2'd0,
    OP_ADD       = 2'd1,
    OP_SET_ENTRY = 2'd2,
    OP_SET_EXIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_EXIT  = 2'd0,
    KIND_TRANS = 2'd1,
    KIND_ENTRY = 2'd2
  } kind_e;

  typedef enum logic {
    REG_HOME_STATE    = 1'b0,
    REG_GROUND_ENABLE = 1'b1
  } reg_e;

  // classified request as it travels through the queue
  typedef struct packed {
    op_e                op;
    logic               use_ground;
    logic [CHAR_W-1:0]  ch;
    logic [STATE_W-1:0] st;
    logic               has_tgt;
    logic [STATE_W-1:0] tgt;
    logic [ACT_W-1:0]   act;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic               has_tgt;
    logic [STATE_W-1:0] tgt;
    logic [ACT_W-1:0]   act;
  } tab_entry_t;

endpackage

`default_nettype wire

FILE: rtl/tdcsm_front.sv
// front end: takes requests, range checks them and tracks the ground start
// depends on tdcsm_pkg
`default_nettype none

module tdcsm_front import tdcsm_pkg::*; #(
  parameter int NUM_STATES  = NUM_STATES_DEF,
  parameter int NUM_ACTIONS = NUM_ACTIONS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [1:0]         operation_i,
  input  wire logic [CHAR_W-1:0]  char_code_i,
  input  wire logic [STATE_W-1:0] state_index_i,
  input  wire logic [STATE_W-1:0] target_state_i,
  input  wire logic               target_present_i,
  input  wire logic [ACT_W-1:0]   action_code_i,
  input  wire logic [STATE_W-1:0] home_state_i,
  input  wire logic               ground_enable_i,
  output logic                    push_o,
  output item_t                   item_o
);

  logic started_q, started_d;
  logic st_ok, tgt_ok, ground_ok, keep;
  logic [ACT_W-1:0] act_clip;

  assign st_ok     = 32'(state_index_i) < NUM_STATES;
  assign tgt_ok    = 32'(target_state_i) < NUM_STATES;
  assign ground_ok = ground_enable_i && (32'(home_state_i) < NUM_STATES);
  assign act_clip  = (32'(action_code_i) < NUM_ACTIONS) ? action_code_i : '0;

  always_comb begin
    item_o.op         = op_e'(operation_i);
    item_o.use_ground = 1'b0;
    item_o.ch         = char_code_i;
    item_o.st         = state_index_i;
    item_o.has_tgt    = target_present_i;
    item_o.tgt        = target_present_i ? target_state_i : '0;
    item_o.act        = act_clip;
    keep              = 1'b0;
    started_d         = started_q;
    unique case (op_e'(operation_i))
      OP_CHAR: begin
        if (started_q) begin
          keep = 1'b1;
        end else if (ground_ok) begin
          // first character: look up from the ground state
          keep              = 1'b1;
          item_o.use_ground = 1'b1;
          item_o.st         = home_state_i;
          if (accept_i) begin
            started_d = 1'b1;
          end
        end
      end
      OP_ADD: begin
        keep = st_ok && (!target_present_i || tgt_ok);
      end
      OP_SET_ENTRY, OP_SET_EXIT: begin
        keep = st_ok;
      end
    endcase
  end

  assign push_o = accept_i && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else begin
      started_q <= started_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tdcsm_queue.sv
// short request queue between the front and back ends
// depends on tdcsm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tdcsm_queue import tdcsm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  input  wire logic  pop_i,
  output logic       full_o,
  output logic       valid_o,
  output item_t      item_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  `ASSERT_NEVER(q_no_overflow, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(q_no_underflow, clk_i, rst_ni, pop_i && !valid_o)
  `ASSERT_CLK(q_count_grows, clk_i, rst_ni, push_i && !pop_i |=> valid_o)

endmodule

`default_nettype wire

FILE: rtl/tdcsm_back.sv
// back end: transition table, state action stores and result sequencing
// depends on tdcsm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tdcsm_back import tdcsm_pkg::*; #(
  parameter int NUM_STATES = NUM_STATES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  item_t                    q_item_i,
  output logic                     q_pop_o,
  output logic                     clear_busy_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [ACT_W-1:0]         emitted_action_o,
  output logic [1:0]               action_kind_o,
  output logic [CHAR_W-1:0]        trigger_char_o,
  output logic [STATE_W-1:0]       resulting_state_o,
  output logic                     last_o
);

  localparam int TAB_STATES = (NUM_STATES < STATE_LIMIT) ? NUM_STATES : STATE_LIMIT;
  localparam int SIDX_W     = $clog2(TAB_STATES);
  localparam int TAB_AW     = SIDX_W + CHAR_W;
  localparam int TAB_DEPTH  = TAB_STATES * (2 ** CHAR_W);

  // transition table and its clearing sweep
  tab_entry_t        tab_mem [TAB_DEPTH];
  tab_entry_t        tab_rd_q, tab_wdata;
  logic              tab_we;
  logic [TAB_AW-1:0] tab_waddr, rd_addr;
  logic              clr_busy_q;
  logic [TAB_AW-1:0] clr_ptr_q;

  // lookup stage
  logic               b_valid_q;
  item_t              b_item_q;
  logic [STATE_W-1:0] b_from_q;
  logic [TAB_AW-1:0]  b_addr_q;
  logic               b_is_char, b_hit, b_changing, b_needs_c, b_adv;
  logic [STATE_W-1:0] b_to_state, cur_state, state_q, rd_state;

  // entry and exit action stores
  logic [ACT_W-1:0]      entry_mem [TAB_STATES];
  logic [ACT_W-1:0]      exit_mem  [TAB_STATES];
  logic [TAB_STATES-1:0] entry_vld_q, exit_vld_q;
  logic                  entry_we, exit_we;
  logic [SIDX_W-1:0]     wr_idx, exit_idx, entry_idx;

  // result stage
  logic               c_valid_q, c_changing_q, c_load, c_ready, c_done;
  logic [2:0]         c_sent_q, mask_raw, mask, sel;
  logic [ACT_W-1:0]   c_exit_q, c_entry_q, c_tact_q;
  logic [CHAR_W-1:0]  c_ch_q;
  logic [STATE_W-1:0] c_state_q;
  logic               out_acc;
  kind_e              kind;

  assign clear_busy_o = clr_busy_q;

  assign b_is_char  = b_item_q.op == OP_CHAR;
  assign b_hit      = tab_rd_q.valid;
  assign b_changing = b_is_char && b_hit && tab_rd_q.has_tgt && (tab_rd_q.tgt != b_from_q);
  assign b_needs_c  = b_is_char && b_hit;
  assign b_to_state = b_changing ? tab_rd_q.tgt : b_from_q;
  // present state straight from the table output when a character is in lookup
  assign cur_state  = (b_valid_q && b_is_char) ? b_to_state : state_q;
  assign b_adv      = b_valid_q && (!b_needs_c || c_ready);
  assign q_pop_o    = q_valid_i && !clr_busy_q && (!b_valid_q || b_adv);

  always_comb begin
    if (q_item_i.op == OP_CHAR) begin
      rd_state = q_item_i.use_ground ? q_item_i.st : cur_state;
    end else begin
      rd_state = q_item_i.st;
    end
  end
  assign rd_addr = {rd_state[SIDX_W-1:0], q_item_i.ch};

  // first write of a transition wins
  always_comb begin
    tab_we    = clr_busy_q || (b_adv && (b_item_q.op == OP_ADD) && !b_hit);
    tab_waddr = clr_busy_q ? clr_ptr_q : b_addr_q;
    if (clr_busy_q) begin
      tab_wdata = '0;
    end else begin
      tab_wdata.valid   = 1'b1;
      tab_wdata.has_tgt = b_item_q.has_tgt;
      tab_wdata.tgt     = b_item_q.tgt;
      tab_wdata.act     = b_item_q.act;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (q_pop_o) begin
      tab_rd_q <= (tab_we && (tab_waddr == rd_addr)) ? tab_wdata : tab_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b_item_q <= q_item_i;
      b_from_q <= rd_state;
      b_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_ptr_q  <= '0;
      b_valid_q  <= 1'b0;
      state_q    <= '0;
    end else begin
      if (clr_busy_q) begin
        if (clr_ptr_q == TAB_AW'(TAB_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_ptr_q <= clr_ptr_q + TAB_AW'(1);
        end
      end
      if (q_pop_o) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      state_q <= cur_state;
    end
  end

  assign entry_we  = b_adv && (b_item_q.op == OP_SET_ENTRY);
  assign exit_we   = b_adv && (b_item_q.op == OP_SET_EXIT);
  assign wr_idx    = b_item_q.st[SIDX_W-1:0];
  assign exit_idx  = b_from_q[SIDX_W-1:0];
  assign entry_idx = b_to_state[SIDX_W-1:0];
  assign c_load    = b_adv && b_needs_c;

  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_mem[wr_idx] <= b_item_q.act;
    end
    if (exit_we) begin
      exit_mem[wr_idx] <= b_item_q.act;
    end
    if (c_load) begin
      c_exit_q     <= exit_vld_q[exit_idx] ? exit_mem[exit_idx] : '0;
      c_entry_q    <= entry_vld_q[entry_idx] ? entry_mem[entry_idx] : '0;
      c_tact_q     <= tab_rd_q.act;
      c_ch_q       <= b_item_q.ch;
      c_state_q    <= b_to_state;
      c_changing_q <= b_changing;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      exit_vld_q  <= '0;
    end else begin
      if (entry_we) begin
        entry_vld_q[wr_idx] <= 1'b1;
      end
      if (exit_we) begin
        exit_vld_q[wr_idx] <= 1'b1;
      end
    end
  end

  // bit 0 exit, bit 1 transition, bit 2 entry
  assign mask_raw = {c_changing_q && (c_entry_q != '0),
                     c_tact_q != '0,
                     c_changing_q && (c_exit_q != '0)};
  assign mask     = mask_raw & ~c_sent_q;

  always_comb begin
    priority if (mask[0]) begin
      sel              = 3'b001;
      kind             = KIND_EXIT;
      emitted_action_o = c_exit_q;
    end else if (mask[1]) begin
      sel              = 3'b010;
      kind             = KIND_TRANS;
      emitted_action_o = c_tact_q;
    end else begin
      sel              = 3'b100;
      kind             = KIND_ENTRY;
      emitted_action_o = c_entry_q;
    end
  end

  assign action_kind_o     = kind;
  assign trigger_char_o    = c_ch_q;
  assign resulting_state_o = c_state_q;
  assign last_o            = (mask & (mask - 3'd1)) == 3'd0;
  assign out_valid_o       = c_valid_q && (mask != 3'd0);
  assign out_acc           = out_valid_o && !out_stall_i;
  assign c_done            = c_valid_q && ((mask == 3'd0) || (out_acc && last_o));
  assign c_ready           = !c_valid_q || c_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      c_sent_q  <= '0;
    end else begin
      if (c_load) begin
        c_valid_q <= 1'b1;
        c_sent_q  <= '0;
      end else if (c_done) begin
        c_valid_q <= 1'b0;
      end else if (out_acc) begin
        c_sent_q <= c_sent_q | sel;
      end
    end
  end

  `ASSERT_NEVER(bk_no_pop_clear, clk_i, rst_ni, clr_busy_q && q_pop_o)
  `ASSERT_NEVER(bk_c_overrun, clk_i, rst_ni, c_load && c_valid_q && !c_done)
  `ASSERT_CLK(bk_results_follow, clk_i, rst_ni, out_acc && !last_o |=> out_valid_o)
  `ASSERT_CLK(bk_state_hold, clk_i, rst_ni, !b_valid_q |=> state_q == $past(state_q))

endmodule

`default_nettype wire

FILE: rtl/table_driven_char_state_machine.sv
// top level of the programmable character state machine
// depends on tdcsm_pkg, tdcsm_front, tdcsm_queue and tdcsm_back
//
// usage: requests arrive on the in channel (in_valid_i / in_stall_o) and carry an
// operation: a character, a transition write, or an entry/exit action write.
// a character produces up to three results on the out channel
// (out_valid_o / out_stall_i): exit, transition and entry action, in that
// order, with last_o set on the final one. writes produce no result.
// throughput: one request per cycle while in_stall_o is low, set by the
// transition table read, whose data feeds the next lookup address in the same
// cycle; a character holds the out channel until its last result is taken.
// result path: a taken request passes the queue write, then the table read,
// then the action read into the result register that drives the out channel.
// reset: clears the present state, the ground start flag, all action codes
// and both registers, then sweeps the transition table one entry a cycle
// with in_stall_o held high.
// a stalled out channel fills the queue and then raises in_stall_o.
// registers home_state (address 0) and ground_enable (address 4) are written by
// the user only while the block is idle; the block itself does not enforce it.
`default_nettype none

module table_driven_char_state_machine import tdcsm_pkg::*; #(
  parameter int NUM_STATES  = NUM_STATES_DEF,
  parameter int NUM_ACTIONS = NUM_ACTIONS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [CHAR_W-1:0]  char_code_i,
  input  wire logic [STATE_W-1:0] state_index_i,
  input  wire logic [STATE_W-1:0] target_state_i,
  input  wire logic               target_present_i,
  input  wire logic [ACT_W-1:0]   action_code_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [ACT_W-1:0]        emitted_action_o,
  output logic [1:0]              action_kind_o,
  output logic [CHAR_W-1:0]       trigger_char_o,
  output logic [STATE_W-1:0]      resulting_state_o,
  output logic                    last_o
);

  logic [STATE_W-1:0] home_state_q;
  logic               ground_enable_q;
  logic               cfg_wr;

  logic  in_accept, push, pop, q_full, q_valid, clear_busy;
  item_t push_item, head_item;

  // configuration registers, no wait states (pready held high)
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_state_q    <= '0;
      ground_enable_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_HOME_STATE:    home_state_q    <= pwdata[STATE_W-1:0];
        REG_GROUND_ENABLE: ground_enable_q <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_HOME_STATE:    prdata = {{(32 - STATE_W){1'b0}}, home_state_q};
      REG_GROUND_ENABLE: prdata = {31'b0, ground_enable_q};
    endcase
  end

  // no request taken while the queue is full or the table sweep runs
  assign in_stall_o = q_full || clear_busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  tdcsm_front #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_accept),
    .operation_i      (operation_i),
    .char_code_i      (char_code_i),
    .state_index_i    (state_index_i),
    .target_state_i   (target_state_i),
    .target_present_i (target_present_i),
    .action_code_i    (action_code_i),
    .home_state_i     (home_state_q),
    .ground_enable_i  (ground_enable_q),
    .push_o           (push),
    .item_o           (push_item)
  );

  // decouples request intake from the lookup and result sequencing
  tdcsm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  tdcsm_back #(
    .NUM_STATES (NUM_STATES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_item_i          (head_item),
    .q_pop_o           (pop),
    .clear_busy_o      (clear_busy),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .emitted_action_o  (emitted_action_o),
    .action_kind_o     (action_kind_o),
    .trigger_char_o    (trigger_char_o),
    .resulting_state_o (resulting_state_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for table_driven_char_state_machine
// uses tdcsm_pkg for codes and widths; predicts every action with its own copy of the machine
`timescale 1ns / 1ps

module tb_top;
  import tdcsm_pkg::*;

  // slack after the last expected action: queue, table read, action read, result register
  localparam int IDLE_SLACK = 16;
  localparam int CHARS      = 256;

  // one request as presented on the in channel
  typedef struct {
    op_e                op;
    logic [CHAR_W-1:0]  ch;
    logic [STATE_W-1:0] st;
    logic [STATE_W-1:0] tgt;
    logic               has_tgt;
    logic [ACT_W-1:0]   act;
  } req_t;

  // one emitted action as seen on the out channel
  typedef struct {
    logic [ACT_W-1:0]   act;
    kind_e              kind;
    logic [CHAR_W-1:0]  ch;
    logic [STATE_W-1:0] state;
    logic               last;
  } action_t;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               psel             = 1'b0;
  logic               penable          = 1'b0;
  logic               pwrite           = 1'b0;
  logic [2:0]         paddr            = '0;
  logic [31:0]        pwdata           = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic [1:0]         operation_i      = '0;
  logic [CHAR_W-1:0]  char_code_i      = '0;
  logic [STATE_W-1:0] state_index_i    = '0;
  logic [STATE_W-1:0] target_state_i   = '0;
  logic               target_present_i = 1'b0;
  logic [ACT_W-1:0]   action_code_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic [ACT_W-1:0]   emitted_action_o;
  logic [1:0]         action_kind_o;
  logic [CHAR_W-1:0]  trigger_char_o;
  logic [STATE_W-1:0] resulting_state_o;
  logic               last_o;

  table_driven_char_state_machine u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .char_code_i       (char_code_i),
    .state_index_i     (state_index_i),
    .target_state_i    (target_state_i),
    .target_present_i  (target_present_i),
    .action_code_i     (action_code_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .emitted_action_o  (emitted_action_o),
    .action_kind_o     (action_kind_o),
    .trigger_char_o    (trigger_char_o),
    .resulting_state_o (resulting_state_o),
    .last_o            (last_o)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow machine: table, per-state action codes, present state and registers
  // ---------------------------------------------------------------------------
  tab_entry_t         trans_tab [NUM_STATES_DEF][CHARS];
  logic [ACT_W-1:0]   entry_act [NUM_STATES_DEF];
  logic [ACT_W-1:0]   exit_act  [NUM_STATES_DEF];
  logic [STATE_W-1:0] sm_state;
  logic               sm_started;
  logic [STATE_W-1:0] gnd_state;
  logic               gnd_en;

  req_t    request_q[$];        // requests waiting for the driver
  action_t pending_actions[$];  // actions predicted but not yet seen
  int      seen_cnt      = 0;
  int      fail_cnt      = 0;

  // pools that keep the random requests hitting defined table entries
  logic [STATE_W-1:0] state_pool [5];
  logic [CHAR_W-1:0]  char_pool  [8];

  // advance the shadow machine by one accepted request
  function automatic void apply_request(req_t r);
    tab_entry_t         e;
    logic [STATE_W-1:0] from;
    logic               changing;
    action_t            batch[$];
    // action codes never reach NUM_ACTIONS at this width, so no clipping applies
    case (r.op)
      OP_ADD: begin
        // first write to an entry wins, later ones are dropped
        if (!trans_tab[r.st][r.ch].valid) begin
          trans_tab[r.st][r.ch] = '{valid: 1'b1, has_tgt: r.has_tgt,
                                    tgt: r.has_tgt ? r.tgt : '0, act: r.act};
        end
      end
      OP_SET_ENTRY: entry_act[r.st] = r.act;
      OP_SET_EXIT:  exit_act[r.st]  = r.act;
      default: begin
        // first character takes the ground state, if one is enabled
        if (!sm_started && gnd_en) begin
          sm_state   = gnd_state;
          sm_started = 1'b1;
        end
        if (sm_started) begin
          e = trans_tab[sm_state][r.ch];
          if (e.valid) begin
            from     = sm_state;
            changing = e.has_tgt && (e.tgt != from);
            if (changing && exit_act[from] != '0)
              batch.push_back('{exit_act[from], KIND_EXIT, r.ch, '0, 1'b0});
            if (e.act != '0)
              batch.push_back('{e.act, KIND_TRANS, r.ch, '0, 1'b0});
            if (changing) begin
              sm_state = e.tgt;
              if (entry_act[e.tgt] != '0)
                batch.push_back('{entry_act[e.tgt], KIND_ENTRY, r.ch, '0, 1'b0});
            end
            // every action carries the state after the character, last flags the final one
            foreach (batch[i]) begin
              batch[i].state = sm_state;
              batch[i].last  = (i == batch.size() - 1);
              pending_actions.push_back(batch[i]);
            end
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of random length, random gaps, payload held while stalled
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    req_t cur;
    logic offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        cur = request_q.pop_front();
        apply_request(cur);
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // a third of the bursts run straight into the next one
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (in_valid_i && in_stall_o) begin
        offer = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        offer = 1'b0;
      end else begin
        offer = (request_q.size() != 0);
      end
      in_valid_i <= offer;
      if (offer) begin
        operation_i      <= request_q[0].op;
        char_code_i      <= request_q[0].ch;
        state_index_i    <= request_q[0].st;
        target_state_i   <= request_q[0].tgt;
        target_present_i <= request_q[0].has_tgt;
        action_code_i    <= request_q[0].act;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: stall pattern of its own, one long hold-off, in-order field checks
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  function automatic void check_field(string name, logic [7:0] expv, logic [7:0] gotv);
    if (gotv !== expv) begin
      $error("%s mismatch: expected %0h, got %0h", name, expv, gotv);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    action_t exp_a;
    logic    nxt_stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen_cnt++;
        if (pending_actions.size() == 0) begin
          $error("action %0h seen with none expected", emitted_action_o);
          fail_cnt++;
        end else begin
          exp_a = pending_actions.pop_front();
          check_field("emitted_action", 8'(exp_a.act), 8'(emitted_action_o));
          check_field("action_kind", 8'(exp_a.kind), 8'(action_kind_o));
          check_field("trigger_char", exp_a.ch, trigger_char_o);
          check_field("resulting_state", 8'(exp_a.state), 8'(resulting_state_o));
          check_field("last", 8'(exp_a.last), 8'(last_o));
        end
      end
      // one long hold-off so the queue fills and the in channel backs up
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (!hold_done && seen_cnt >= 12) begin
        hold_done = 1'b1;
        hold_left = 120;
        nxt_stall = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 64);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0:       nxt_stall = 1'b0;                            // free flow
          1:       nxt_stall = ($urandom_range(0, 3) == 0);     // light
          2:       nxt_stall = ($urandom_range(0, 3) != 0);     // heavy
          default: nxt_stall = mode_left[0];                    // alternating
        endcase
      end
      out_stall_i <= nxt_stall;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic void push_req(op_e op, logic [CHAR_W-1:0] ch, logic [STATE_W-1:0] st,
                                   logic [STATE_W-1:0] tgt, logic has_tgt,
                                   logic [ACT_W-1:0] act);
    request_q.push_back('{op, ch, st, tgt, has_tgt, act});
  endfunction

  // mostly table writes and characters drawn from the pools, with some stray ones
  function automatic void push_random();
    int unsigned pick;
    op_e         op;
    pick = $urandom_range(0, 99);
    if (pick < 30)      op = OP_ADD;
    else if (pick < 40) op = OP_SET_ENTRY;
    else if (pick < 50) op = OP_SET_EXIT;
    else                op = OP_CHAR;
    push_req(op,
             ($urandom_range(0, 9) == 0) ? 8'($urandom) : char_pool[$urandom_range(0, 7)],
             ($urandom_range(0, 7) == 0) ? 4'($urandom) : state_pool[$urandom_range(0, 4)],
             state_pool[$urandom_range(0, 4)],
             ($urandom_range(0, 3) != 0),
             4'($urandom));
  endfunction

  // register write: setup cycle, then access cycle until pready
  task automatic write_reg(reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_HOME_STATE) gnd_state = value[STATE_W-1:0];
    else                       gnd_en    = value[0];
  endtask

  // sender pause: everything accepted, every action seen, pipeline drained
  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid_i || pending_actions.size() != 0)
      @(posedge clk_i);
    repeat (IDLE_SLACK) @(posedge clk_i);
  endtask

  task automatic set_ground(logic [STATE_W-1:0] st, logic en);
    write_reg(REG_HOME_STATE, 32'(st));
    write_reg(REG_GROUND_ENABLE, 32'(en));
  endtask

  initial begin
    int n;
    foreach (trans_tab[s, c]) trans_tab[s][c] = '0;
    foreach (entry_act[s]) begin
      entry_act[s] = '0;
      exit_act[s]  = '0;
    end
    sm_state   = '0;
    sm_started = 1'b0;
    gnd_state  = '0;
    gnd_en     = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // table clearing sweep holds in_stall_o high
    repeat (2) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    // directed part, ground at the top state but not yet enabled
    set_ground(4'hF, 1'b0);
    push_req(OP_CHAR,      8'h41, 4'h0, 4'h0, 1'b0, 4'h0);  // not started, ignored
    push_req(OP_ADD,       8'h00, 4'hF, 4'h0, 1'b1, 4'hF);
    push_req(OP_ADD,       8'h00, 4'hF, 4'h3, 1'b1, 4'h2);  // repeated write, dropped
    push_req(OP_SET_EXIT,  8'h00, 4'hF, 4'h0, 1'b0, 4'hF);
    push_req(OP_SET_EXIT,  8'h00, 4'hF, 4'h0, 1'b0, 4'h9);  // overwrites, last wins
    push_req(OP_SET_ENTRY, 8'h00, 4'h0, 4'h0, 1'b0, 4'h1);
    push_req(OP_ADD,       8'hFF, 4'h0, 4'hF, 1'b0, 4'h0);  // stay, no action
    push_req(OP_ADD,       8'h80, 4'h0, 4'h0, 1'b1, 4'h7);  // self loop, transition only
    push_req(OP_SET_EXIT,  8'h00, 4'h0, 4'h0, 1'b0, 4'h4);
    push_req(OP_ADD,       8'h55, 4'h0, 4'hA, 1'b1, 4'h0);
    push_req(OP_ADD,       8'hAA, 4'hA, 4'hF, 1'b1, 4'h5);
    push_req(OP_SET_ENTRY, 8'h00, 4'hF, 4'h0, 1'b0, 4'hF);
    push_req(OP_SET_ENTRY, 8'h00, 4'hA, 4'h0, 1'b0, 4'h0);
    wait_idle();

    // enable ground: first character starts from state 15
    set_ground(4'hF, 1'b1);
    push_req(OP_CHAR, 8'h01, 4'h0, 4'h0, 1'b0, 4'h0);  // missing entry
    push_req(OP_CHAR, 8'h00, 4'h0, 4'h0, 1'b0, 4'h0);  // exit, transition, entry
    push_req(OP_CHAR, 8'hFF, 4'h0, 4'h0, 1'b0, 4'h0);  // entry found, nothing emitted
    push_req(OP_CHAR, 8'h80, 4'h0, 4'h0, 1'b0, 4'h0);
    push_req(OP_CHAR, 8'h55, 4'h0, 4'h0, 1'b0, 4'h0);  // exit only
    push_req(OP_CHAR, 8'hAA, 4'h0, 4'h0, 1'b0, 4'h0);
    push_req(OP_CHAR, 8'h00, 4'h0, 4'h0, 1'b0, 4'h0);
    // run of self loops: one action each, the long hold-off lands in here
    repeat (16) push_req(OP_CHAR, 8'h80, 4'h0, 4'h0, 1'b0, 4'h0);
    wait_idle();

    // random part; state 0 stays in the pool since the machine sits there now
    state_pool[0] = 4'h0;
    for (int i = 1; i < 5; i++) state_pool[i] = 4'($urandom);
    foreach (char_pool[i]) char_pool[i] = 8'($urandom);

    // ground registers no longer move a started machine
    set_ground(4'h0, 1'b0);
    repeat (30) push_random();
    wait_idle();

    set_ground(4'($urandom), 1'b1);
    repeat (30) push_random();
    wait_idle();

    // last phase fed a few at a time
    set_ground(4'hF, 1'b1);
    n = 0;
    while (n < 30) begin
      push_random();
      n++;
      while (request_q.size() > 4) @(posedge clk_i);
    end
    wait_idle();
    repeat (40) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard: far beyond the slowest legal run
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
